/* rtl/color_temperature_gamma_ramp_macros.svh */
// assertion macros for the color temperature gamma ramp block
`ifndef COLOR_TEMPERATURE_GAMMA_RAMP_MACROS_SVH
`define COLOR_TEMPERATURE_GAMMA_RAMP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define CTGR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ctgr assertion failed");
// next-cycle implication, held off during reset
`define CTGR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ctgr assertion failed");
`else
`define CTGR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define CTGR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

/* rtl/ctgr_pkg.sv */
// shared types and constants of the gamma ramp pipeline
package ctgr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TEMPERATURE = 2'd0;
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd1;
    localparam logic [1:0] REG_RAMP_SIZE   = 2'd2;

    localparam logic [15:0] LOW_TEMP       = 16'd700;
    localparam logic [15:0] NEUTRAL_TEMP   = 16'd6500;
    localparam logic [15:0] NEUTRAL_OFFSET = 16'd5800;
    localparam logic [16:0] ONE_Q16        = 17'd65536;

    // coefficients in q.24, rounded to nearest
    localparam longint COEF_LOW_G0  =
        -((64'sd147751309140 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000);
    localparam longint COEF_LOW_G1  =
        (64'sd28590164772 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;
    localparam longint COEF_LOW_B0  =
        -((64'sd438321650115 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000);
    localparam longint COEF_LOW_B1  =
        (64'sd62121587694 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;
    localparam longint COEF_HIGH_R0 =
        (64'sd175390204039 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;
    localparam longint COEF_HIGH_R1 =
        -((64'sd11508056715 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000);
    localparam longint COEF_HIGH_G0 =
        (64'sd149221604915 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;
    localparam longint COEF_HIGH_G1 =
        -((64'sd7513509589 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000);
    localparam longint LN2_Q24_L    =
        (64'sd69314718056 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;

    localparam logic [23:0] LN2_Q24 = 24'(LN2_Q24_L);

    // k0 pre-shifted into q.48, k1 kept as q.24
    localparam logic signed [55:0] LOW_G_BIAS  = 56'(COEF_LOW_G0 * 64'sd16777216);
    localparam logic signed [55:0] LOW_B_BIAS  = 56'(COEF_LOW_B0 * 64'sd16777216);
    localparam logic signed [55:0] HIGH_R_BIAS = 56'(COEF_HIGH_R0 * 64'sd16777216);
    localparam logic signed [55:0] HIGH_G_BIAS = 56'(COEF_HIGH_G0 * 64'sd16777216);
    localparam logic signed [24:0] LOW_G_SLOPE  = 25'(COEF_LOW_G1);
    localparam logic signed [24:0] LOW_B_SLOPE  = 25'(COEF_LOW_B1);
    localparam logic signed [24:0] HIGH_R_SLOPE = 25'(COEF_HIGH_R1);
    localparam logic signed [24:0] HIGH_G_SLOPE = 25'(COEF_HIGH_G1);

    // channel positions in a gain set
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {
        RANGE_COLD,
        RANGE_WARM,
        RANGE_NEUTRAL
    } range_t;

    // per-beat side data that travels with the pipeline
    typedef struct packed {
        logic [11:0] idx;
        logic        invalid;
        range_t      mode;
        logic        xzero;
    } tag_t;

    typedef logic [16:0] gain_t;
    typedef gain_t [2:0] gain_set_t;

endpackage

/* rtl/color_temperature_gamma_ramp.sv */
// top level of the color temperature gamma ramp entry generator
//
// usage:
// - configuration: write cfg_wdata to register cfg_index when cfg_we is high;
//   0 temperature in kelvin, 1 brightness in q1.16, 2 ramp size; other
//   indexes are dropped. write only while no beat is in flight
// - request: a beat is taken on every clock edge with start high and busy
//   low; entry_index names the ramp position
// - busy never rises: the pipeline takes one beat per cycle, every cycle
// - result: done rises with the result beat, so red_level, green_level,
//   blue_level and index_invalid are valid while done is high
// - latency is set by the 16 squaring stages of the log2 unit and the
//   16 stages of the per-channel restoring divider, plus 10 other stages
// - throughput: one beat per clock, results in request order
// - reset clears all valid bits and loads 6500 K, full brightness and a
//   ramp of 256 entries
// - the receiver cannot stall; done is a pure strobe
// - an index at or past the ramp size gives index_invalid and zero levels
module color_temperature_gamma_ramp #(
    parameter int MAX_RAMP_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] entry_index,
    output logic        done,
    output logic [15:0] red_level,
    output logic [15:0] green_level,
    output logic [15:0] blue_level,
    output logic        index_invalid,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    import ctgr_pkg::*;

`include "color_temperature_gamma_ramp_macros.svh"

    localparam int PipeLatency = 42;

    // configuration
    logic [15:0] temperature_reg;
    logic [16:0] brightness_reg;
    logic [12:0] ramp_size_reg;

    // effective values seen by the pipeline
    logic [16:0] bright_eff;
    logic [12:0] size_eff;

    // request stage
    logic        valid0_reg;
    tag_t        tag0_reg;
    logic [15:0] x0_reg;
    tag_t        tag0_next;
    logic [15:0] x0_next;

    logic        log_valid;
    tag_t        log_tag;
    logic [19:0] log_value;
    logic        gain_valid;
    tag_t        gain_tag;
    gain_set_t   gains;

    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temperature_reg <= NEUTRAL_TEMP;
            brightness_reg  <= ONE_Q16;
            ramp_size_reg   <= 13'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMPERATURE: temperature_reg <= cfg_wdata[15:0];
                REG_BRIGHTNESS:  brightness_reg  <= cfg_wdata;
                REG_RAMP_SIZE:   ramp_size_reg   <= cfg_wdata[12:0];
                default:         ;
            endcase
        end
    end

    // brightness saturates at one, size at the ramp capacity
    always_comb
    begin
        bright_eff = (brightness_reg > ONE_Q16) ? ONE_Q16 : brightness_reg;
        if (32'(ramp_size_reg) > MAX_RAMP_ENTRIES)
            size_eff = 13'(MAX_RAMP_ENTRIES);
        else
            size_eff = ramp_size_reg;
    end

    // pick the temperature band and the log argument
    always_comb
    begin
        tag0_next.idx     = entry_index;
        tag0_next.invalid = {1'b0, entry_index} >= size_eff;
        if (temperature_reg < LOW_TEMP)
        begin
            tag0_next.mode = RANGE_COLD;
            x0_next        = 16'd0;
        end
        else if (temperature_reg < NEUTRAL_TEMP)
        begin
            tag0_next.mode = RANGE_WARM;
            x0_next        = temperature_reg - LOW_TEMP;
        end
        else
        begin
            tag0_next.mode = RANGE_NEUTRAL;
            x0_next        = temperature_reg - NEUTRAL_OFFSET;
        end
        // exactly 700 K: ln of zero, green and blue gains forced to zero
        tag0_next.xzero = (x0_next == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        tag0_reg <= tag0_next;
        x0_reg   <= x0_next;
    end

    ctgr_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid0_reg),
        .in_tag    (tag0_reg),
        .in_x      (x0_reg),
        .out_valid (log_valid),
        .out_tag   (log_tag),
        .out_log   (log_value)
    );

    ctgr_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (log_valid),
        .in_tag    (log_tag),
        .in_log    (log_value),
        .out_valid (gain_valid),
        .out_tag   (gain_tag),
        .out_gains (gains)
    );

    ctgr_level u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (gain_valid),
        .in_tag        (gain_tag),
        .in_gains      (gains),
        .brightness    (bright_eff),
        .ramp_size     (size_eff),
        .out_valid     (done),
        .red_level     (red_level),
        .green_level   (green_level),
        .blue_level    (blue_level),
        .index_invalid (index_invalid)
    );

    // an invalid index never leaks a level
    `CTGR_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, done && index_invalid,
        red_level == 16'd0 && green_level == 16'd0 && blue_level == 16'd0)
    // every strobe traces back to an accepted request
    `CTGR_ASSERT_IMPLY(a_done_from_req, clk, rst_n, done, $past(accept, PipeLatency))
    // strobes last exactly one cycle per request
    `CTGR_ASSERT_NEXT(a_done_single, clk, rst_n, done && !$past(accept, PipeLatency - 1),
        !done)

endmodule

/* rtl/ctgr_log2.sv */
// pipelined log2 in q4.16: normalize stage then one squaring stage per fraction bit
module ctgr_log2 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ctgr_pkg::tag_t in_tag,
    input  logic [15:0]    in_x,
    output logic           out_valid,
    output ctgr_pkg::tag_t out_tag,
    output logic [19:0]    out_log
);
    import ctgr_pkg::*;

    localparam int Steps = 16;

    logic [3:0]  e_next;
    logic [31:0] m_next;

    logic        valid_reg [0:Steps];
    tag_t        tag_reg   [0:Steps];
    logic [3:0]  e_reg     [0:Steps];
    logic [31:0] m_reg     [0:Steps];
    logic [15:0] frac_reg  [0:Steps];

    // top set bit and mantissa aligned to q1.31
    always_comb
    begin
        e_next = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (in_x[i])
            begin
                e_next = 4'(i);
            end
        end
        m_next = 32'(in_x) << (5'd31 - {1'b0, e_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Steps; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < Steps; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= in_tag;
        e_reg[0]    <= e_next;
        m_reg[0]    <= m_next;
        frac_reg[0] <= '0;
    end

    for (genvar g = 0; g < Steps; g++)
    begin : g_step
        logic [63:0] sq;
        logic [32:0] sq_shr;
        logic        bit_out;

        always_comb
        begin
            sq      = m_reg[g] * m_reg[g];
            sq_shr  = sq[63:31];
            bit_out = sq_shr[32];
        end

        always_ff @(posedge clk)
        begin
            tag_reg[g+1]  <= tag_reg[g];
            e_reg[g+1]    <= e_reg[g];
            m_reg[g+1]    <= bit_out ? sq_shr[32:1] : sq_shr[31:0];
            frac_reg[g+1] <= {frac_reg[g][14:0], bit_out};
        end
    end

    assign out_valid = valid_reg[Steps];
    assign out_tag   = tag_reg[Steps];
    assign out_log   = {e_reg[Steps], frac_reg[Steps]};

endmodule

/* rtl/ctgr_gain.sv */
// ln scaling, coefficient fit, clamp and channel gain selection
module ctgr_gain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ctgr_pkg::tag_t      in_tag,
    input  logic [19:0]         in_log,
    output logic                out_valid,
    output ctgr_pkg::tag_t      out_tag,
    output ctgr_pkg::gain_set_t out_gains
);
    import ctgr_pkg::*;

    logic [2:0]  valid_reg;
    tag_t        tag1_reg, tag2_reg, tag3_reg;
    logic [27:0] ln_reg;
    logic signed [55:0] acc_a_reg, acc_b_reg;
    gain_set_t   gains_reg;

    logic [43:0] ln_prod;
    logic [27:0] ln_next;
    logic signed [55:0] bias_a, bias_b;
    logic signed [24:0] slope_a, slope_b;
    logic signed [28:0] ln_s;
    logic signed [53:0] prod_a, prod_b;
    logic signed [55:0] acc_a_next, acc_b_next;
    gain_t       gain_a, gain_b;
    gain_set_t   gains_next;

    function automatic gain_t clamp_gain(input logic signed [55:0] acc);
        logic signed [55:0] rounded;
        rounded = acc + 56'sd2147483648;
        if (acc <= 56'sd0)
            clamp_gain = 17'd0;
        else if (acc >= (56'sd1 <<< 48))
            clamp_gain = ONE_Q16;
        else
            clamp_gain = rounded[48:32];
    endfunction

    // ln = log2 * ln2, rounded back to q.24
    always_comb
    begin
        ln_prod = in_log * LN2_Q24;
        ln_next = 28'((ln_prod + 44'd32768) >> 16);
    end

    always_comb
    begin
        if (tag1_reg.mode == RANGE_NEUTRAL)
        begin
            bias_a  = HIGH_R_BIAS;
            slope_a = HIGH_R_SLOPE;
            bias_b  = HIGH_G_BIAS;
            slope_b = HIGH_G_SLOPE;
        end
        else
        begin
            bias_a  = LOW_G_BIAS;
            slope_a = LOW_G_SLOPE;
            bias_b  = LOW_B_BIAS;
            slope_b = LOW_B_SLOPE;
        end
        ln_s       = signed'({1'b0, ln_reg});
        prod_a     = slope_a * ln_s;
        prod_b     = slope_b * ln_s;
        acc_a_next = bias_a + 56'(prod_a);
        acc_b_next = bias_b + 56'(prod_b);
    end

    always_comb
    begin
        gain_a = tag2_reg.xzero ? 17'd0 : clamp_gain(acc_a_reg);
        gain_b = tag2_reg.xzero ? 17'd0 : clamp_gain(acc_b_reg);
        case (tag2_reg.mode)
            RANGE_WARM:
            begin
                gains_next[CH_RED]   = ONE_Q16;
                gains_next[CH_GREEN] = gain_a;
                gains_next[CH_BLUE]  = gain_b;
            end
            RANGE_NEUTRAL:
            begin
                gains_next[CH_RED]   = gain_a;
                gains_next[CH_GREEN] = gain_b;
                gains_next[CH_BLUE]  = ONE_Q16;
            end
            default:
            begin
                gains_next[CH_RED]   = ONE_Q16;
                gains_next[CH_GREEN] = 17'd0;
                gains_next[CH_BLUE]  = 17'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg  <= in_tag;
        ln_reg    <= ln_next;
        tag2_reg  <= tag1_reg;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        tag3_reg  <= tag2_reg;
        gains_reg <= gains_next;
    end

    assign out_valid = valid_reg[2];
    assign out_tag   = tag3_reg;
    assign out_gains = gains_reg;

endmodule

/* rtl/ctgr_level.sv */
// level scaling and pipelined restoring division by the ramp size
module ctgr_level (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ctgr_pkg::tag_t      in_tag,
    input  ctgr_pkg::gain_set_t in_gains,
    input  logic [16:0]         brightness,
    input  logic [12:0]         ramp_size,
    output logic                out_valid,
    output logic [15:0]         red_level,
    output logic [15:0]         green_level,
    output logic [15:0]         blue_level,
    output logic                index_invalid
);
    import ctgr_pkg::*;

    localparam int Steps = 16;
    localparam int Front = 3;

    logic       fvalid_reg [0:Front-1];
    tag_t       ftag_reg   [0:Front-1];
    logic       dvalid_reg [0:Steps];
    logic       dinv_reg   [0:Steps];
    logic       done_reg;
    logic       invalid_reg;
    logic [15:0] level_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Front; i++)
            begin
                fvalid_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= Steps; i++)
            begin
                dvalid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            fvalid_reg[0] <= in_valid;
            for (int i = 1; i < Front; i++)
            begin
                fvalid_reg[i] <= fvalid_reg[i-1];
            end
            dvalid_reg[0] <= fvalid_reg[Front-1];
            for (int i = 0; i < Steps; i++)
            begin
                dvalid_reg[i+1] <= dvalid_reg[i];
            end
            done_reg <= dvalid_reg[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        ftag_reg[0] <= in_tag;
        for (int i = 1; i < Front; i++)
        begin
            ftag_reg[i] <= ftag_reg[i-1];
        end
        dinv_reg[0] <= ftag_reg[Front-1].invalid;
        for (int i = 0; i < Steps; i++)
        begin
            dinv_reg[i+1] <= dinv_reg[i];
        end
        invalid_reg <= dinv_reg[Steps];
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [32:0] p_reg;
        logic [43:0] r_reg;
        logic [59:0] q_reg;
        logic [33:0] p_full;
        logic [44:0] r_full;
        logic [60:0] q_full;
        logic [60:0] h_sum;
        logic [12:0] rem_reg [0:Steps];
        logic [15:0] low_reg [0:Steps];
        logic [15:0] quo_reg [0:Steps];

        always_comb
        begin
            p_full = brightness * in_gains[c];
            r_full = p_reg * ftag_reg[0].idx;
            q_full = {1'b0, r_reg, 16'd0} - {17'd0, r_reg};
            h_sum  = {1'b0, q_reg} + {17'd0, ramp_size, 31'd0};
        end

        always_ff @(posedge clk)
        begin
            p_reg      <= p_full[32:0];
            r_reg      <= r_full[43:0];
            q_reg      <= q_full[59:0];
            rem_reg[0] <= h_sum[60:48];
            low_reg[0] <= h_sum[47:32];
            quo_reg[0] <= '0;
        end

        // one quotient bit per stage
        for (genvar s = 0; s < Steps; s++)
        begin : g_div
            logic [13:0] trial;
            logic [13:0] diff;
            logic        ge;

            always_comb
            begin
                trial = {rem_reg[s], low_reg[s][15]};
                diff  = trial - {1'b0, ramp_size};
                ge    = trial >= {1'b0, ramp_size};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= ge ? diff[12:0] : trial[12:0];
                low_reg[s+1] <= {low_reg[s][14:0], 1'b0};
                quo_reg[s+1] <= {quo_reg[s][14:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            level_reg[c] <= dinv_reg[Steps] ? 16'd0 : quo_reg[Steps];
        end
    end

    assign out_valid     = done_reg;
    assign index_invalid = invalid_reg;
    assign red_level     = level_reg[CH_RED];
    assign green_level   = level_reg[CH_GREEN];
    assign blue_level    = level_reg[CH_BLUE];

endmodule
